>>> design/mlbb_pkg.sv
// Shared constants and types for the monochrome line buffer blitter.
`default_nettype none

package mlbb_pkg;

    localparam int LINES_DEF     = 64;
    localparam int ROW_BYTES_DEF = 50;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        FUNC_RECT   = 3'd0,
        FUNC_GLYPH  = 3'd1,
        FUNC_STORE  = 3'd2,
        FUNC_FILL   = 3'd3,
        FUNC_INVERT = 3'd4,
        FUNC_READ   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_SET    = 2'd1,
        MODE_INVERT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OP_CLR = 2'd0,
        OP_SET = 2'd1,
        OP_XOR = 2'd2,
        OP_WR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_WR   = 2'd2,
        S_DONE = 2'd3
    } state_t;

endpackage

`default_nettype wire

>>> design/monochrome_line_buffer_blitter.sv
// Top level of the monochrome line buffer blitter: sequencer and line store.
//
// Input channel (in_valid/in_ready) takes one command beat: func, x, y, width,
// height, mode, value. Output channel (out_valid/out_ready) returns one beat
// per command carrying read_data (the byte for a read, zero otherwise).
// The line store is a single-port memory of LINES*ROW_BYTES bytes; one
// shared read-modify-write path walks it one byte per step under a small
// sequencer, and in_ready is high only while the sequencer is idle.
// Steps from accept to result valid, with the output register free:
//   unknown and out-of-range commands: straight to done; store byte: write
//   read byte: read, then capture; glyph: read and write per touched byte
//   fill rectangle and invert lines: read and write per touched byte
//   fill lines: write only over rows*ROW_BYTES bytes, one byte a cycle
// The single memory port sets these steps: a modified byte takes a read
// step and a write step. The sequencer returns to idle as the result is
// registered and accepts the next command from there.
// A finished result waits in the output register while the next command is
// accepted; a further result holds in the sequencer until out_ready frees
// the register. Reset clears the sequencer and out_valid; the store content
// stays undefined until written.
`default_nettype none

module monochrome_line_buffer_blitter #(
    parameter int LINES     = mlbb_pkg::LINES_DEF,
    parameter int ROW_BYTES = mlbb_pkg::ROW_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] func,
    input  wire logic [8:0] x,
    input  wire logic [5:0] y,
    input  wire logic [8:0] width,
    input  wire logic [6:0] height,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data
);

    localparam int DEPTH      = LINES * ROW_BYTES;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int RW         = $clog2(LINES + 1);
    localparam int ROW_PIXELS = ROW_BYTES * 8;

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q;

    mlbb_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       read_data_reg, read_data_next;

    mlbb_pkg::op_t op_reg, op_next;
    logic          is_read_reg, is_read_next;
    logic [7:0]    value_reg, value_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    last_reg, last_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] col_start_reg, col_start_next;
    logic [CW-1:0] col_end_reg, col_end_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] row_end_reg, row_end_next;
    logic [7:0]    res_reg, res_next;

    logic          accept;
    logic          fire_out;
    logic [5:0]    col_x;
    logic          y_ok;
    logic          col_ok;
    logic [11:0]   xsum;
    logic [11:0]   xend;
    logic [11:0]   xend_m1;
    logic [7:0]    ysum;
    logic [7:0]    lines_n;
    logic [15:0]   glyph_word;
    logic          setup_ok;
    logic [AW-1:0] addr;
    logic          we;
    logic [7:0]    mask;
    logic [7:0]    wdata;
    logic          last_col;
    logic          last_row;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == mlbb_pkg::S_IDLE);
    assign fire_out = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    assign col_x      = x[8:3];
    assign y_ok       = 32'(y) < LINES;
    assign col_ok     = 32'(col_x) < ROW_BYTES;
    assign xsum       = {3'b000, x} + {3'b000, width};
    assign xend       = (32'(xsum) > ROW_PIXELS) ? 12'(ROW_PIXELS) : xsum;
    assign xend_m1    = xend - 12'd1;
    assign ysum       = {2'b00, y} + {1'b0, height};
    assign lines_n    = (32'(height) > LINES) ? 8'(LINES) : {1'b0, height};
    assign glyph_word = {8'h00, value} << x[2:0];

    assign addr     = base_reg + AW'(col_reg);
    assign last_col = (col_reg == col_end_reg);
    assign last_row = ((row_reg + RW'(1)) == row_end_reg);

    always_comb
    begin
        mask = ((col_reg == col_start_reg) ? first_reg : mlbb_pkg::BYTE_ONES)
             & (last_col ? last_reg : mlbb_pkg::BYTE_ONES);
        unique case (op_reg)
            mlbb_pkg::OP_CLR: wdata = mem_q & ~mask;
            mlbb_pkg::OP_SET: wdata = mem_q | mask;
            mlbb_pkg::OP_XOR: wdata = mem_q ^ mask;
            default:          wdata = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        mem_q <= mem[addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        op_next        = op_reg;
        is_read_next   = is_read_reg;
        value_next     = value_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_next       = row_reg;
        row_end_next   = row_end_reg;
        res_next       = res_reg;
        setup_ok       = 1'b0;
        we             = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mlbb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // defaults suit a single-byte command at (x/8, y)
                    op_next        = mlbb_pkg::OP_WR;
                    is_read_next   = 1'b0;
                    value_next     = value;
                    first_next     = mlbb_pkg::BYTE_ONES;
                    last_next      = mlbb_pkg::BYTE_ONES;
                    base_next      = AW'(32'(y) * ROW_BYTES);
                    col_next       = CW'(col_x);
                    col_start_next = CW'(col_x);
                    col_end_next   = CW'(col_x);
                    row_next       = RW'(y);
                    row_end_next   = RW'(32'(y) + 1);
                    res_next       = 8'h00;
                    unique case (func) inside
                        mlbb_pkg::FUNC_RECT:
                        begin
                            setup_ok = (width != 9'd0) && (height != 7'd0) && col_ok && y_ok;
                            unique case (mode)
                                mlbb_pkg::MODE_CLEAR: op_next = mlbb_pkg::OP_CLR;
                                mlbb_pkg::MODE_SET:   op_next = mlbb_pkg::OP_SET;
                                default:              op_next = mlbb_pkg::OP_XOR;
                            endcase
                            first_next   = mlbb_pkg::BYTE_ONES << x[2:0];
                            last_next    = mlbb_pkg::BYTE_ONES >> (3'd7 - xend_m1[2:0]);
                            col_end_next = CW'(xend_m1[11:3]);
                            row_end_next = (32'(ysum) > LINES) ? RW'(LINES) : RW'(ysum);
                        end
                        mlbb_pkg::FUNC_GLYPH:
                        begin
                            setup_ok   = y_ok && col_ok;
                            op_next    = mlbb_pkg::OP_CLR;
                            first_next = glyph_word[7:0];
                            // skip the second byte past the end of the row
                            if ((32'(col_x) + 1) < ROW_BYTES)
                            begin
                                col_end_next = CW'(32'(col_x) + 1);
                                last_next    = glyph_word[15:8];
                            end
                        end
                        mlbb_pkg::FUNC_STORE:
                        begin
                            setup_ok = y_ok && col_ok;
                        end
                        mlbb_pkg::FUNC_FILL, mlbb_pkg::FUNC_INVERT:
                        begin
                            setup_ok       = (lines_n != 8'd0);
                            op_next        = (func == mlbb_pkg::FUNC_FILL) ? mlbb_pkg::OP_WR
                                                                           : mlbb_pkg::OP_XOR;
                            base_next      = '0;
                            col_next       = '0;
                            col_start_next = '0;
                            col_end_next   = CW'(ROW_BYTES - 1);
                            row_next       = '0;
                            row_end_next   = RW'(lines_n);
                        end
                        mlbb_pkg::FUNC_READ:
                        begin
                            setup_ok     = y_ok && col_ok;
                            is_read_next = 1'b1;
                        end
                        default:
                        begin
                            setup_ok = 1'b0;
                        end
                    endcase
                    if (!setup_ok)
                    begin
                        state_next = mlbb_pkg::S_DONE;
                    end
                    else if ((func == mlbb_pkg::FUNC_STORE) || (func == mlbb_pkg::FUNC_FILL))
                    begin
                        state_next = mlbb_pkg::S_WR;
                    end
                    else
                    begin
                        state_next = mlbb_pkg::S_RD;
                    end
                end
            end
            mlbb_pkg::S_RD:
            begin
                state_next = mlbb_pkg::S_WR;
            end
            mlbb_pkg::S_WR:
            begin
                if (is_read_reg)
                begin
                    res_next   = mem_q;
                    state_next = mlbb_pkg::S_DONE;
                end
                else
                begin
                    we = 1'b1;
                    if (!last_col)
                    begin
                        col_next = col_reg + CW'(1);
                    end
                    else
                    begin
                        // advance to the next row, rewind the column
                        col_next  = col_start_reg;
                        row_next  = row_reg + RW'(1);
                        base_next = base_reg + AW'(ROW_BYTES);
                    end
                    if (last_col && last_row)
                    begin
                        state_next = mlbb_pkg::S_DONE;
                    end
                    else if (op_reg == mlbb_pkg::OP_WR)
                    begin
                        state_next = mlbb_pkg::S_WR;
                    end
                    else
                    begin
                        state_next = mlbb_pkg::S_RD;
                    end
                end
            end
            mlbb_pkg::S_DONE:
            begin
                // hold the result until the output register frees
                if (fire_out)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = res_reg;
                    state_next     = mlbb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mlbb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlbb_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        op_reg        <= op_next;
        is_read_reg   <= is_read_next;
        value_reg     <= value_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        base_reg      <= base_next;
        col_reg       <= col_next;
        col_start_reg <= col_start_next;
        col_end_reg   <= col_end_next;
        row_reg       <= row_next;
        row_end_reg   <= row_end_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the monochrome line buffer blitter with a shadow pixel store.
`default_nettype none

module tb_top;

    localparam int ROW_PIXELS   = mlbb_pkg::ROW_BYTES_DEF * 8;
    localparam int STORE_BYTES  = mlbb_pkg::LINES_DEF * mlbb_pkg::ROW_BYTES_DEF;
    localparam int RANDOM_ITEMS = 550;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_ALIAS_INVERT = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [8:0] x;
        logic [5:0] y;
        logic [8:0] width;
        logic [6:0] height;
        logic [1:0] mode;
        logic [7:0] value;
    } cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       out_ready = 1'b0;
    cmd_t       in_cmd = '0;
    wire        in_ready;
    wire        out_valid;
    wire  [7:0] read_data;

    cmd_t       pending_cmds[$];
    logic [7:0] read_bytes_due[$];
    logic [7:0] pixel_shadow [STORE_BYTES];
    logic [7:0] due_byte;
    int         func_seen [8];
    int         in_count = 0;
    int         out_count = 0;
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         total_cmds;
    int         phase1_end;
    int         phase2_end;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         last_x = 0;
    int         last_y = 0;

    monochrome_line_buffer_blitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (in_cmd.func),
        .x         (in_cmd.x),
        .y         (in_cmd.y),
        .width     (in_cmd.width),
        .height    (in_cmd.height),
        .mode      (in_cmd.mode),
        .value     (in_cmd.value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

    always #4 clk = ~clk;

    always_comb
    begin
        if (in_count < phase1_end)
        begin
            send_idle_pct = 9;
            recv_idle_pct = 58;
        end
        else if (in_count < phase2_end)
        begin
            send_idle_pct = 58;
            recv_idle_pct = 9;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    task automatic touch_byte(input int idx, input logic [7:0] mask, input logic [1:0] m);
        if (m == mlbb_pkg::MODE_CLEAR)
            pixel_shadow[idx] = pixel_shadow[idx] & ~mask;
        else if (m == mlbb_pkg::MODE_SET)
            pixel_shadow[idx] = pixel_shadow[idx] | mask;
        else
            pixel_shadow[idx] = pixel_shadow[idx] ^ mask;
    endtask

    // Update the shadow store for one accepted command and queue its result byte.
    task automatic predict_command(input cmd_t c);
        int         px, py, pw, ph, xe, ye, row, col, lo, hi, lines;
        logic [7:0] mask;
        logic [7:0] rd;
        logic [15:0] word;
        px = int'(c.x);
        py = int'(c.y);
        pw = int'(c.width);
        ph = int'(c.height);
        rd = '0;
        func_seen[c.func]++;
        case (c.func)
            mlbb_pkg::FUNC_RECT:
            begin
                if (pw != 0 && ph != 0 && px < ROW_PIXELS && py < mlbb_pkg::LINES_DEF)
                begin
                    xe = (px + pw > ROW_PIXELS) ? ROW_PIXELS : px + pw;
                    ye = (py + ph > mlbb_pkg::LINES_DEF) ? mlbb_pkg::LINES_DEF : py + ph;
                    for (row = py; row < ye; row++)
                        for (col = px / 8; col <= (xe - 1) / 8; col++)
                        begin
                            lo = (px > col * 8) ? px - col * 8 : 0;
                            hi = (xe - col * 8 >= 8) ? 8 : xe - col * 8;
                            mask = mlbb_pkg::BYTE_ONES << lo;
                            mask = mask & (mlbb_pkg::BYTE_ONES >> (8 - hi));
                            touch_byte(row * mlbb_pkg::ROW_BYTES_DEF + col, mask, c.mode);
                        end
                end
            end
            mlbb_pkg::FUNC_GLYPH:
            begin
                word = {8'h00, c.value} << c.x[2:0];
                col = px / 8;
                if (py < mlbb_pkg::LINES_DEF)
                begin
                    if (col < mlbb_pkg::ROW_BYTES_DEF)
                        touch_byte(py * mlbb_pkg::ROW_BYTES_DEF + col, word[7:0],
                                   mlbb_pkg::MODE_CLEAR);
                    if (col + 1 < mlbb_pkg::ROW_BYTES_DEF)
                        touch_byte(py * mlbb_pkg::ROW_BYTES_DEF + col + 1, word[15:8],
                                   mlbb_pkg::MODE_CLEAR);
                end
            end
            mlbb_pkg::FUNC_STORE:
            begin
                if (py < mlbb_pkg::LINES_DEF && px / 8 < mlbb_pkg::ROW_BYTES_DEF)
                    pixel_shadow[py * mlbb_pkg::ROW_BYTES_DEF + px / 8] = c.value;
            end
            mlbb_pkg::FUNC_FILL, mlbb_pkg::FUNC_INVERT:
            begin
                lines = (ph > mlbb_pkg::LINES_DEF) ? mlbb_pkg::LINES_DEF : ph;
                for (int i = 0; i < lines * mlbb_pkg::ROW_BYTES_DEF; i++)
                    pixel_shadow[i] = (c.func == mlbb_pkg::FUNC_FILL) ? c.value
                                                                      : ~pixel_shadow[i];
            end
            mlbb_pkg::FUNC_READ:
            begin
                if (py < mlbb_pkg::LINES_DEF && px / 8 < mlbb_pkg::ROW_BYTES_DEF)
                    rd = pixel_shadow[py * mlbb_pkg::ROW_BYTES_DEF + px / 8];
            end
            default: ;
        endcase
        read_bytes_due.push_back(rd);
    endtask

    function automatic cmd_t make_cmd(input logic [2:0] f, input int px, input int py,
                                      input int w, input int h, input logic [1:0] m,
                                      input int v);
        cmd_t c;
        c.func   = f;
        c.x      = 9'(px);
        c.y      = 6'(py);
        c.width  = 9'(w);
        c.height = 7'(h);
        c.mode   = m;
        c.value  = 8'(v);
        return c;
    endfunction

    task automatic make_random_command(output cmd_t c);
        int pick;
        pick     = $urandom_range(99);
        c.x      = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 400))
                                            : 9'($urandom_range(399));
        c.y      = 6'($urandom_range(63));
        c.width  = 9'($urandom_range(511));
        c.height = 7'($urandom_range(127));
        c.mode   = 2'($urandom_range(3));
        c.value  = 8'($urandom_range(255));
        if (pick < 22)
        begin
            c.func = mlbb_pkg::FUNC_RECT;
            // keep most rectangles small so the run stays short
            if ($urandom_range(9) != 0)
            begin
                c.width  = 9'($urandom_range(48));
                c.height = 7'($urandom_range(8));
            end
        end
        else if (pick < 42)
            c.func = mlbb_pkg::FUNC_GLYPH;
        else if (pick < 60)
            c.func = mlbb_pkg::FUNC_STORE;
        else if (pick < 66)
        begin
            c.func = (pick < 63) ? mlbb_pkg::FUNC_FILL : mlbb_pkg::FUNC_INVERT;
            if ($urandom_range(9) < 7)
                c.height = 7'($urandom_range(8));
        end
        else if (pick < 96)
        begin
            c.func = mlbb_pkg::FUNC_READ;
            // read back the last written spot half the time
            if ($urandom_range(1) == 0)
            begin
                c.x = 9'(last_x);
                c.y = 6'(last_y);
            end
        end
        else
            c.func = ($urandom_range(1) == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
        if (c.func == mlbb_pkg::FUNC_GLYPH || c.func == mlbb_pkg::FUNC_STORE
            || c.func == mlbb_pkg::FUNC_RECT)
        begin
            last_x = int'(c.x);
            last_y = int'(c.y);
        end
    endtask

    // Driver: present the next pending command, hold it until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_command(in_cmd);
                in_count <= in_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_cmd   <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expected byte.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_count++;
                if (read_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %02h",
                             $time, read_data);
                    mismatches++;
                end
                else
                begin
                    due_byte = read_bytes_due.pop_front();
                    if (read_data !== due_byte)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, due_byte, read_data);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t c;
        for (int i = 0; i < STORE_BYTES; i++)
            pixel_shadow[i] = '0;
        // write every byte first so nothing below touches an unwritten entry
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_FILL, 0, 0, 0, mlbb_pkg::LINES_DEF,
                                        mlbb_pkg::MODE_CLEAR, 8'h00));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_STORE, 0, 0, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 8'hA5));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 0, 0, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_STORE, 399, 63, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 8'hFF));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_STORE, 400, 5, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 8'h3C));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 511, 5, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_GLYPH, 397, 63, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 8'hFF));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 392, 63, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_GLYPH, 3, 0, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 8'h81));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 8, 0, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 3, 1, 0, 5,
                                        mlbb_pkg::MODE_SET, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 3, 1, 10, 0,
                                        mlbb_pkg::MODE_SET, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 5, 2, 20, 3,
                                        mlbb_pkg::MODE_SET, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 8, 3, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 2, 2, 12, 1,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 390, 60, 511, 127,
                                        MODE_ALIAS_INVERT, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 392, 63, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 400, 0, 8, 1,
                                        mlbb_pkg::MODE_SET, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_RECT, 8, 0, 16, 2,
                                        mlbb_pkg::MODE_INVERT, 0));
        pending_cmds.push_back(make_cmd(FUNC_SPARE_LO, 0, 0, 0, 0, mlbb_pkg::MODE_SET, 8'hFF));
        pending_cmds.push_back(make_cmd(FUNC_SPARE_HI, 0, 0, 0, 0, mlbb_pkg::MODE_SET, 8'hFF));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_INVERT, 0, 0, 0, 3,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_READ, 0, 2, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_INVERT, 0, 0, 0, 0,
                                        mlbb_pkg::MODE_CLEAR, 0));
        pending_cmds.push_back(make_cmd(mlbb_pkg::FUNC_FILL, 0, 0, 0, 127,
                                        mlbb_pkg::MODE_CLEAR, 8'h5A));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            make_random_command(c);
            pending_cmds.push_back(c);
        end
        total_cmds = pending_cmds.size();
        phase1_end = total_cmds / 3;
        phase2_end = 2 * total_cmds / 3;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (in_count < total_cmds)
            @(posedge clk);
        while (read_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: rect %0d, glyph %0d, store %0d, fill %0d, invert %0d,",
                 in_count, func_seen[mlbb_pkg::FUNC_RECT], func_seen[mlbb_pkg::FUNC_GLYPH],
                 func_seen[mlbb_pkg::FUNC_STORE], func_seen[mlbb_pkg::FUNC_FILL],
                 func_seen[mlbb_pkg::FUNC_INVERT]);
        $display("read %0d, unused codes %0d; %0d result beats checked.",
                 func_seen[mlbb_pkg::FUNC_READ],
                 func_seen[FUNC_SPARE_LO] + func_seen[FUNC_SPARE_HI], out_count);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> monochrome_line_buffer_blitter.f
design/mlbb_pkg.sv
design/monochrome_line_buffer_blitter.sv
sim/tb_top.sv
